[rtl/core/qrv_pkg.sv]
// qrv_pkg: shared widths, payload structs and helpers for the quaternion rotation core.
// No dependencies; imported by every module under rtl/core.
`timescale 1ns / 1ps

package qrv_pkg;

    localparam int QW         = 16;          // quaternion component width
    localparam int VW         = 16;          // vector component width
    localparam int PW         = 2 * QW;      // quaternion pair product
    localparam int CW         = PW + 2;      // rotation matrix coefficient
    localparam int MW         = CW + VW;     // coefficient times vector component
    localparam int SW         = MW + 2;      // sum of three terms
    localparam int FRAC_SHIFT = 28;          // Q1.14 squared
    localparam int RW         = SW - FRAC_SHIFT;
    localparam int OUT_MAX    = 32767;
    localparam int OUT_MIN    = -32768;

    typedef struct packed {
        logic signed [QW-1:0] w;
        logic signed [QW-1:0] z;
        logic signed [QW-1:0] y;
        logic signed [QW-1:0] x;
    } quat_t;

    typedef struct packed {
        logic signed [VW-1:0] z;
        logic signed [VW-1:0] y;
        logic signed [VW-1:0] x;
    } vec_t;

    typedef struct packed {
        logic signed [PW-1:0] xx;
        logic signed [PW-1:0] yy;
        logic signed [PW-1:0] zz;
        logic signed [PW-1:0] ww;
        logic signed [PW-1:0] xy;
        logic signed [PW-1:0] xz;
        logic signed [PW-1:0] yz;
        logic signed [PW-1:0] wx;
        logic signed [PW-1:0] wy;
        logic signed [PW-1:0] wz;
    } prod_t;

    typedef struct packed {
        logic signed [CW-1:0] m00;
        logic signed [CW-1:0] m01;
        logic signed [CW-1:0] m02;
        logic signed [CW-1:0] m10;
        logic signed [CW-1:0] m11;
        logic signed [CW-1:0] m12;
        logic signed [CW-1:0] m20;
        logic signed [CW-1:0] m21;
        logic signed [CW-1:0] m22;
    } mat_t;

    typedef struct packed {
        logic signed [SW-1:0] z;
        logic signed [SW-1:0] y;
        logic signed [SW-1:0] x;
    } acc_t;

    typedef struct packed {
        logic                 clip;
        logic signed [VW-1:0] z;
        logic signed [VW-1:0] y;
        logic signed [VW-1:0] x;
    } res_t;

    function automatic logic signed [PW-1:0] mul_qq(
        input logic signed [QW-1:0] a,
        input logic signed [QW-1:0] b
    );
        return a * b;
    endfunction

    function automatic logic signed [MW-1:0] mul_cv(
        input logic signed [CW-1:0] c,
        input logic signed [VW-1:0] v
    );
        return c * v;
    endfunction

endpackage

[rtl/core/qrv_products.sv]
// qrv_products: first pipeline stage, the ten quaternion pair products.
// Depends on qrv_pkg.
`timescale 1ns / 1ps

module qrv_products
    import qrv_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    output logic  in_ready,
    input  quat_t in_quat,
    input  vec_t  in_vec,
    output logic  out_valid,
    input  logic  out_ready,
    output prod_t out_prod,
    output vec_t  out_vec
);

    logic  valid_reg;
    prod_t prod_reg, prod_next;
    vec_t  vec_reg;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        prod_next.xx = mul_qq(in_quat.x, in_quat.x);
        prod_next.yy = mul_qq(in_quat.y, in_quat.y);
        prod_next.zz = mul_qq(in_quat.z, in_quat.z);
        prod_next.ww = mul_qq(in_quat.w, in_quat.w);
        prod_next.xy = mul_qq(in_quat.x, in_quat.y);
        prod_next.xz = mul_qq(in_quat.x, in_quat.z);
        prod_next.yz = mul_qq(in_quat.y, in_quat.z);
        prod_next.wx = mul_qq(in_quat.w, in_quat.x);
        prod_next.wy = mul_qq(in_quat.w, in_quat.y);
        prod_next.wz = mul_qq(in_quat.w, in_quat.z);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            prod_reg <= prod_next;
            vec_reg  <= in_vec;
        end
    end

    assign out_valid = valid_reg;
    assign out_prod  = prod_reg;
    assign out_vec   = vec_reg;

endmodule

[rtl/core/qrv_matrix.sv]
// qrv_matrix: second pipeline stage, the nine rotation matrix coefficients.
// Depends on qrv_pkg.
`timescale 1ns / 1ps

module qrv_matrix
    import qrv_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    output logic  in_ready,
    input  prod_t in_prod,
    input  vec_t  in_vec,
    output logic  out_valid,
    input  logic  out_ready,
    output mat_t  out_mat,
    output vec_t  out_vec
);

    logic                 valid_reg;
    mat_t                 mat_reg, mat_next;
    vec_t                 vec_reg;
    logic signed [CW-1:0] xx, yy, zz, ww, xy, xz, yz, wx, wy, wz;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        xx = CW'(in_prod.xx);
        yy = CW'(in_prod.yy);
        zz = CW'(in_prod.zz);
        ww = CW'(in_prod.ww);
        xy = CW'(in_prod.xy);
        xz = CW'(in_prod.xz);
        yz = CW'(in_prod.yz);
        wx = CW'(in_prod.wx);
        wy = CW'(in_prod.wy);
        wz = CW'(in_prod.wz);

        mat_next.m00 = ww + xx - yy - zz;
        mat_next.m01 = (xy - wz) <<< 1;
        mat_next.m02 = (xz + wy) <<< 1;
        mat_next.m10 = (xy + wz) <<< 1;
        mat_next.m11 = ww - xx + yy - zz;
        mat_next.m12 = (yz - wx) <<< 1;
        mat_next.m20 = (xz - wy) <<< 1;
        mat_next.m21 = (yz + wx) <<< 1;
        mat_next.m22 = ww - xx - yy + zz;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            mat_reg <= mat_next;
            vec_reg <= in_vec;
        end
    end

    assign out_valid = valid_reg;
    assign out_mat   = mat_reg;
    assign out_vec   = vec_reg;

endmodule

[rtl/core/qrv_mac.sv]
// qrv_mac: third and fourth pipeline stages, matrix-vector products then row sums.
// Depends on qrv_pkg; the row sums carry the rounding offset for the final shift.
`timescale 1ns / 1ps

module qrv_mac
    import qrv_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  mat_t in_mat,
    input  vec_t in_vec,
    output logic out_valid,
    input  logic out_ready,
    output acc_t out_acc
);

    localparam logic signed [SW-1:0] ROUND_HALF =
        {{(SW - FRAC_SHIFT){1'b0}}, 1'b1, {(FRAC_SHIFT - 1){1'b0}}};

    // multiply stage
    logic                 mul_valid_reg;
    logic                 mul_ready;
    logic signed [MW-1:0] p_reg [9];
    logic signed [MW-1:0] p_next [9];

    // sum stage
    logic sum_valid_reg;
    acc_t acc_reg, acc_next;

    assign mul_ready = !sum_valid_reg || out_ready;
    assign in_ready  = !mul_valid_reg || mul_ready;

    always_comb begin
        p_next[0] = mul_cv(in_mat.m00, in_vec.x);
        p_next[1] = mul_cv(in_mat.m01, in_vec.y);
        p_next[2] = mul_cv(in_mat.m02, in_vec.z);
        p_next[3] = mul_cv(in_mat.m10, in_vec.x);
        p_next[4] = mul_cv(in_mat.m11, in_vec.y);
        p_next[5] = mul_cv(in_mat.m12, in_vec.z);
        p_next[6] = mul_cv(in_mat.m20, in_vec.x);
        p_next[7] = mul_cv(in_mat.m21, in_vec.y);
        p_next[8] = mul_cv(in_mat.m22, in_vec.z);
    end

    always_comb begin
        acc_next.x = SW'(p_reg[0]) + SW'(p_reg[1]) + SW'(p_reg[2]) + ROUND_HALF;
        acc_next.y = SW'(p_reg[3]) + SW'(p_reg[4]) + SW'(p_reg[5]) + ROUND_HALF;
        acc_next.z = SW'(p_reg[6]) + SW'(p_reg[7]) + SW'(p_reg[8]) + ROUND_HALF;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_valid_reg <= 1'b0;
            sum_valid_reg <= 1'b0;
        end else begin
            if (in_ready) begin
                mul_valid_reg <= in_valid;
            end
            if (mul_ready) begin
                sum_valid_reg <= mul_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            p_reg <= p_next;
        end
        if (mul_ready && mul_valid_reg) begin
            acc_reg <= acc_next;
        end
    end

    assign out_valid = sum_valid_reg;
    assign out_acc   = acc_reg;

endmodule

[rtl/core/qrv_round_sat.sv]
// qrv_round_sat: last pipeline stage, drop the fraction, saturate to 16 bits, flag clipping.
// Depends on qrv_pkg; this stage is also the output register of the core.
`timescale 1ns / 1ps

module qrv_round_sat
    import qrv_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  acc_t in_acc,
    output logic out_valid,
    input  logic out_ready,
    output res_t out_res
);

    localparam logic signed [RW-1:0] SAT_HI = RW'(OUT_MAX);
    localparam logic signed [RW-1:0] SAT_LO = RW'(OUT_MIN);

    logic                 valid_reg;
    res_t                 res_reg, res_next;
    logic signed [RW-1:0] rx, ry, rz;
    logic                 cx, cy, cz;

    function automatic logic signed [VW-1:0] clamp(input logic signed [RW-1:0] r);
        if (r > SAT_HI) begin
            return VW'(SAT_HI);
        end else if (r < SAT_LO) begin
            return VW'(SAT_LO);
        end
        return VW'(r);
    endfunction

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        // rounding offset was added upstream: floor by arithmetic shift
        rx = in_acc.x[SW-1:FRAC_SHIFT];
        ry = in_acc.y[SW-1:FRAC_SHIFT];
        rz = in_acc.z[SW-1:FRAC_SHIFT];
        cx = (rx > SAT_HI) || (rx < SAT_LO);
        cy = (ry > SAT_HI) || (ry < SAT_LO);
        cz = (rz > SAT_HI) || (rz < SAT_LO);
        res_next.x    = clamp(rx);
        res_next.y    = clamp(ry);
        res_next.z    = clamp(rz);
        res_next.clip = cx || cy || cz;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            res_reg <= res_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

[rtl/core/quaternion_rotate_vector_core.sv]
// quaternion_rotate_vector_core: top level, stream ports and the five-stage rotation pipeline.
// Depends on qrv_pkg, qrv_products, qrv_matrix, qrv_mac and qrv_round_sat.
//
// Usage:
//   Each request on the s_ channel carries a quaternion (Q1.14) and a 16-bit
//   vector; the m_ channel returns exactly one result per request, in order:
//   the vector rotated by q v q*, rounded half up and saturated to 16 bits,
//   with m_tuser set when any component saturated. The quaternion is taken
//   as given, so a non-unit quaternion scales the result by its squared norm.
//   Pipeline: 5 register stages (pair products, matrix coefficients,
//   coefficient-vector products, row sums, round and saturate); m_tvalid
//   rises once a request has passed through each of them in that order.
//   Throughput: one request per cycle while the receiver keeps m_tready high.
//   Each stage has its own valid bit and takes new data whenever it is empty
//   or its successor moves, so bubbles close up and requests keep being
//   accepted while a result waits in the output register.
//   When the receiver stalls, results hold in place; s_tready drops only once
//   every stage is full. Reset (aresetn low, synchronous) empties the
//   pipeline; no other state exists.
`timescale 1ns / 1ps

module quaternion_rotate_vector_core
    import qrv_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    // request channel
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [111:0] s_tdata,  // quat_x, quat_y, quat_z, quat_w, vec_x, vec_y, vec_z
    // result channel
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [47:0]  m_tdata,  // rot_x, rot_y, rot_z
    output logic [0:0]   m_tuser   // clipped
);

    quat_t in_quat;
    vec_t  in_vec;

    // unpack the request, lowest field first
    assign in_quat.x = s_tdata[15:0];
    assign in_quat.y = s_tdata[31:16];
    assign in_quat.z = s_tdata[47:32];
    assign in_quat.w = s_tdata[63:48];
    assign in_vec.x  = s_tdata[79:64];
    assign in_vec.y  = s_tdata[95:80];
    assign in_vec.z  = s_tdata[111:96];

    logic  prod_valid, prod_ready;
    prod_t prod;
    vec_t  prod_vec;

    logic  mat_valid, mat_ready;
    mat_t  mat;
    vec_t  mat_vec;

    logic  acc_valid, acc_ready;
    acc_t  acc;

    res_t  res;

    // stage 1: quaternion pair products
    qrv_products u_products (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_quat   (in_quat),
        .in_vec    (in_vec),
        .out_valid (prod_valid),
        .out_ready (prod_ready),
        .out_prod  (prod),
        .out_vec   (prod_vec)
    );

    // stage 2: rotation matrix
    qrv_matrix u_matrix (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (prod_valid),
        .in_ready  (prod_ready),
        .in_prod   (prod),
        .in_vec    (prod_vec),
        .out_valid (mat_valid),
        .out_ready (mat_ready),
        .out_mat   (mat),
        .out_vec   (mat_vec)
    );

    // stages 3 and 4: products and row sums with rounding offset
    qrv_mac u_mac (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (mat_valid),
        .in_ready  (mat_ready),
        .in_mat    (mat),
        .in_vec    (mat_vec),
        .out_valid (acc_valid),
        .out_ready (acc_ready),
        .out_acc   (acc)
    );

    // stage 5: shift, saturate, output register
    qrv_round_sat u_round_sat (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (acc_valid),
        .in_ready  (acc_ready),
        .in_acc    (acc),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res)
    );

    // pack the result, lowest field first
    assign m_tdata = {res.z, res.y, res.x};
    assign m_tuser = res.clip;

    // pipeline comes out of reset empty
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // back pressure on the request side only when every stage holds an item
    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready && prod_valid && mat_valid && acc_valid))
        else $error("request stalled while the pipeline has room");

    // a clipped flag needs at least one component at a saturation bound
    a_clip_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |->
            (res.x == VW'(OUT_MAX) || res.x == VW'(OUT_MIN) ||
             res.y == VW'(OUT_MAX) || res.y == VW'(OUT_MIN) ||
             res.z == VW'(OUT_MAX) || res.z == VW'(OUT_MIN)))
        else $error("clipped flag without a saturated component");

    // a stalled stage before the output holds its item
    a_acc_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (acc_valid && !acc_ready) |=> (acc_valid && $stable(acc)))
        else $error("row sums changed while stalled");

endmodule

[sim/quaternion_rotate_vector_core_tb.sv]
// quaternion_rotate_vector_core_tb: self-checking bench for the quaternion rotation core.
// Depends on qrv_pkg and quaternion_rotate_vector_core; drives directed and random requests.
`timescale 1ns / 1ps

module quaternion_rotate_vector_core_tb
    import qrv_pkg::*;
();

    localparam int N_RANDOM    = 430;
    localparam int STALL_LIMIT = 5000;   // cycles with no transfer on either channel
    localparam int DRAIN_WAIT  = 16;     // pipeline is 5 deep; allow generous slack

    typedef enum {KIND_ROT, KIND_WIDE, KIND_EXTREME} quat_kind_t;
    typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_RUNS} rx_mode_t;

    typedef struct {
        quat_t q;
        vec_t  v;
        bit    typed;   // expected result written by hand below
        res_t  want;
    } rot_req_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [111:0] s_tdata;   // quat_x, quat_y, quat_z, quat_w, vec_x, vec_y, vec_z
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [47:0]  m_tdata;   // rot_x, rot_y, rot_z
    logic [0:0]   m_tuser;   // clipped

    rot_req_t dir_tab[$];
    res_t     expected_rot_q[$];
    int       errors      = 0;
    int       n_sent      = 0;
    int       n_got       = 0;
    int       n_clip      = 0;
    int       idle_cycles = 0;

    rx_mode_t rx_mode = RX_OPEN;
    int       rx_left = 0;
    int       rx_run  = 0;

    quaternion_rotate_vector_core DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Shift a 2^28-scaled sum down with round half up, then clamp to 16 bits.
    function automatic logic [15:0] round_clamp(input longint s, output bit sat);
        longint r;
        r = (s + (longint'(1) << (FRAC_SHIFT - 1))) >>> FRAC_SHIFT;
        sat = 1'b0;
        if (r > OUT_MAX) begin
            r = longint'(OUT_MAX);
            sat = 1'b1;
        end else if (r < OUT_MIN) begin
            r = longint'(OUT_MIN);
            sat = 1'b1;
        end
        return r[15:0];
    endfunction

    // Expanded q v q* with exact 64-bit products; the quaternion is not normalized.
    function automatic res_t predict_rotation(input quat_t q, input vec_t v);
        longint x, y, z, w, vx, vy, vz;
        longint xx, yy, zz, ww, xy, xz, yz, wx, wy, wz;
        longint sum_x, sum_y, sum_z;
        bit     sat_x, sat_y, sat_z;
        res_t   r;
        x  = longint'(q.x);
        y  = longint'(q.y);
        z  = longint'(q.z);
        w  = longint'(q.w);
        vx = longint'(v.x);
        vy = longint'(v.y);
        vz = longint'(v.z);
        xx = x * x;  yy = y * y;  zz = z * z;  ww = w * w;
        xy = x * y;  xz = x * z;  yz = y * z;
        wx = w * x;  wy = w * y;  wz = w * z;
        sum_x = (ww + xx - yy - zz) * vx + 2 * (xy - wz) * vy + 2 * (xz + wy) * vz;
        sum_y = 2 * (xy + wz) * vx + (ww - xx + yy - zz) * vy + 2 * (yz - wx) * vz;
        sum_z = 2 * (xz - wy) * vx + 2 * (yz + wx) * vy + (ww - xx - yy + zz) * vz;
        r.x    = round_clamp(sum_x, sat_x);
        r.y    = round_clamp(sum_y, sat_y);
        r.z    = round_clamp(sum_z, sat_z);
        r.clip = sat_x | sat_y | sat_z;
        return r;
    endfunction

    function automatic logic [15:0] pick_quat_comp(input quat_kind_t kind);
        int extreme_vals[5] = '{-32768, -16384, 0, 16384, 32767};
        case (kind)
            KIND_ROT:  return 16'($urandom_range(0, 16384) - 8192);   // |q| <= 1
            KIND_WIDE: return 16'($urandom_range(0, 65535));
            default:   return 16'(extreme_vals[$urandom_range(0, 4)]);
        endcase
    endfunction

    function automatic logic [15:0] pick_vec_comp();
        int extreme_vals[5] = '{-32768, -1, 0, 1, 32767};
        if ($urandom_range(0, 4) == 0)
            return 16'(extreme_vals[$urandom_range(0, 4)]);
        return 16'($urandom_range(0, 65535));
    endfunction

    // Append one directed row; typed rows carry a hand-derived expectation.
    task automatic add_row(input int qx, qy, qz, qw, vx, vy, vz,
                           input bit typed = 1'b0,
                           input int ex = 0, ey = 0, ez = 0, input bit ec = 1'b0);
        rot_req_t r;
        r.q.x = 16'(qx);  r.q.y = 16'(qy);  r.q.z = 16'(qz);  r.q.w = 16'(qw);
        r.v.x = 16'(vx);  r.v.y = 16'(vy);  r.v.z = 16'(vz);
        r.typed  = typed;
        r.want.x = 16'(ex);  r.want.y = 16'(ey);  r.want.z = 16'(ez);
        r.want.clip = ec;
        dir_tab.push_back(r);
    endtask

    // Receiver: switch between open, coin-flip, sparse and long-run stall patterns.
    always @(posedge aclk) begin
        if (rx_left == 0) begin
            rx_mode <= rx_mode_t'($urandom_range(0, 3));
            rx_left <= $urandom_range(20, 120);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            RX_OPEN:   m_tready <= 1'b1;
            RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
            RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
            default: begin
                // hold the current level for a random run, then flip it
                if (rx_run == 0) begin
                    m_tready <= ~m_tready;
                    rx_run   <= $urandom_range(1, 15);
                end else begin
                    rx_run <= rx_run - 1;
                end
            end
        endcase
    end

    // Result checker: compare each result with the oldest pending expectation.
    always @(posedge aclk) begin : check_results
        res_t got;
        res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tuser, m_tdata};
            n_got++;
            if (got.clip)
                n_clip++;
            if (expected_rot_q.size() == 0) begin
                errors++;
                $error("unexpected result: rot_x %0d rot_y %0d rot_z %0d clipped %0d",
                       $signed(got.x), $signed(got.y), $signed(got.z), got.clip);
            end else begin
                want = expected_rot_q.pop_front();
                if (got.x !== want.x) begin
                    errors++;
                    $error("rot_x: expected %0d, got %0d", $signed(want.x), $signed(got.x));
                end
                if (got.y !== want.y) begin
                    errors++;
                    $error("rot_y: expected %0d, got %0d", $signed(want.y), $signed(got.y));
                end
                if (got.z !== want.z) begin
                    errors++;
                    $error("rot_z: expected %0d, got %0d", $signed(want.z), $signed(got.z));
                end
                if (got.clip !== want.clip) begin
                    errors++;
                    $error("clipped: expected %0d, got %0d", want.clip, got.clip);
                end
            end
        end
    end

    // Watchdog: end the run if neither channel moves for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == STALL_LIMIT) begin
            $display("** quaternion_rotate_vector_core: FAILED **");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Stimulus: directed table first, then random requests, sent in bursts.
    initial begin : stimulus
        rot_req_t   cur;
        quat_kind_t kind;
        int         burst_left;
        int         gap;
        int         total;
        int         pick;

        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;

        // identity, plain and at the vector extremes; negated identity is the same rotation
        add_row(0, 0, 0, 16384,  100, -200, 300,  1,  100, -200, 300, 0);
        add_row(0, 0, 0, 16384,  32767, -32768, 32767,  1,  32767, -32768, 32767, 0);
        add_row(0, 0, 0, -16384,  7, 8, 9,  1,  7, 8, 9, 0);
        // zero quaternion wipes out any vector
        add_row(0, 0, 0, 0,  -32768, 32767, -32768,  1,  0, 0, 0, 0);
        add_row(0, 0, 0, 0,  -1, -1, -1,  1,  0, 0, 0, 0);
        // half turns about each axis
        add_row(16384, 0, 0, 0,  1, 2, 3,  1,  1, -2, -3, 0);
        add_row(0, 16384, 0, 0,  1, 2, 3,  1,  -1, 2, -3, 0);
        add_row(0, 0, 16384, 0,  1, 2, 3,  1,  -1, -2, 3, 0);
        // w = 0.5 scales by 1/4: exact halves round up, toward positive infinity
        add_row(0, 0, 0, 8192,  2, -2, 6,  1,  1, 0, 2, 0);
        add_row(0, 0, 0, 8192,  -6, -1, 1,  1,  -1, 0, 0, 0);
        // w = -2 scales by 4: saturate high and low in one result
        add_row(0, 0, 0, -32768,  10000, -10000, 1,  1,  32767, -32768, 4, 1);
        // zero vector stays zero whatever the quaternion
        add_row(12000, -5000, 7000, 9000,  0, 0, 0,  1,  0, 0, 0, 0);
        // extremes and general cases, left to the predictor
        add_row(0, 0, 0, 32767,  32767, 32767, 32767);
        add_row(-32768, -32768, -32768, -32768,  -32768, -32768, -32768);
        add_row(32767, 32767, 32767, 32767,  32767, -32768, 1);
        add_row(-32768, 32767, 0, 0,  1, -1, 0);
        add_row(0, 0, 11585, 11585,  1000, 0, 0);
        add_row(5000, -7000, 3000, 12000,  12345, -23456, 31000);
        add_row(100, 200, -300, 400,  32767, 32767, 32767);
        add_row(-16384, 16384, -16384, 16384,  -20000, 15000, -32768);

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        total      = dir_tab.size() + N_RANDOM;
        burst_left = 0;
        for (int i = 0; i < total; i++) begin
            if (i < dir_tab.size()) begin
                cur = dir_tab[i];
            end else begin
                pick = $urandom_range(0, 19);
                kind = (pick < 12) ? KIND_ROT : (pick < 17) ? KIND_WIDE : KIND_EXTREME;
                cur.q.x   = pick_quat_comp(kind);
                cur.q.y   = pick_quat_comp(kind);
                cur.q.z   = pick_quat_comp(kind);
                cur.q.w   = pick_quat_comp(kind);
                cur.v.x   = pick_vec_comp();
                cur.v.y   = pick_vec_comp();
                cur.v.z   = pick_vec_comp();
                cur.typed = 1'b0;
            end

            // open a new burst, idling the sender first unless the gap is zero
            if (burst_left == 0) begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                if (gap > 0) begin
                    s_tvalid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
                burst_left = $urandom_range(1, 16);
            end

            s_tvalid <= 1'b1;
            s_tdata  <= {cur.v, cur.q};
            do @(posedge aclk); while (!s_tready);
            expected_rot_q.push_back(cur.typed ? cur.want : predict_rotation(cur.q, cur.v));
            n_sent++;
            burst_left--;
        end
        s_tvalid <= 1'b0;

        // drain every pending result, then watch for strays
        while (expected_rot_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        $display("Sent %0d rotation requests (%0d directed, %0d random) under random stalls;",
                 n_sent, dir_tab.size(), n_sent - dir_tab.size());
        $display("checked %0d results, %0d of them saturated, %0d mismatches.",
                 n_got, n_clip, errors);
        if (errors == 0) begin
            $display("** quaternion_rotate_vector_core: PASSED **");
        end else begin
            $display("** quaternion_rotate_vector_core: FAILED **");
        end
        $finish;
    end

endmodule
